/* sv/ude_pkg.sv */
// ude_pkg: shared types, constants and helpers of the utf-8 byte decoder
// used by ude_decode, ude_result_buf and utf8_decoder_byte_escape_top
`default_nettype none

package ude_pkg;

	localparam int RES_MAX = 4;
	localparam int HOLD_DEPTH = 3;

	localparam logic [20:0] ESC_BASE = 21'h00DC80;

	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	typedef logic [20:0] cp_t;
	typedef logic [2:0] cnt_t;

	typedef struct packed {
		cp_t        code_point;
		logic [2:0] byte_count;
		logic       escaped;
	} result_t;

	// results caused by one request, slot 0 first
	typedef struct packed {
		result_t [RES_MAX-1:0] entries;
		cnt_t                  count;
	} batch_t;

	function automatic result_t esc_result(input logic [7:0] b);
		result_t r;
		r.code_point = ESC_BASE | {14'd0, b[6:0]};
		r.byte_count = 3'd1;
		r.escaped    = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/ude_decode.sv */
// ude_decode: pending-sequence state and per-request decode into a result batch
// depends on ude_pkg
`default_nettype none

module ude_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    in_byte,
	input  wire logic          stream_end,
	output ude_pkg::batch_t    batch
);
	import ude_pkg::*;

	logic [1:0] hc_q;
	logic [2:0] sl_q;
	logic [7:0] held_q [HOLD_DEPTH];

	logic       is_cont;
	logic       is_bad_lead;
	logic [2:0] lead_len;
	logic       flush;
	logic       cur_valid;
	logic       hold_first;
	logic       hold_next;
	result_t    cur;
	cp_t        done_cp;

	always_comb begin
		unique case (sl_q)
			SEQ_LEN2: done_cp = {10'd0, held_q[0][4:0], in_byte[5:0]};
			SEQ_LEN3: done_cp = {5'd0, held_q[0][3:0], held_q[1][5:0], in_byte[5:0]};
			default:  done_cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
				in_byte[5:0]};
		endcase
	end

	always_comb begin
		is_cont     = (in_byte[7:6] == 2'b10);
		is_bad_lead = (in_byte[7:3] == 5'b11111);
		if (!in_byte[5])
			lead_len = SEQ_LEN2;
		else if (!in_byte[4])
			lead_len = SEQ_LEN3;
		else
			lead_len = SEQ_LEN4;

		flush      = 1'b0;
		cur_valid  = 1'b0;
		hold_first = 1'b0;
		hold_next  = 1'b0;
		cur        = esc_result(in_byte);

		if (hc_q != 2'd0 && is_cont) begin
			if ({1'b0, hc_q} + 3'd1 >= sl_q) begin
				cur_valid       = 1'b1;
				cur.code_point  = done_cp;
				cur.byte_count  = sl_q;
				cur.escaped     = 1'b0;
			end else if (stream_end) begin
				flush     = 1'b1;
				cur_valid = 1'b1;
			end else begin
				hold_next = 1'b1;
			end
		end else begin
			flush = (hc_q != 2'd0);
			if (!in_byte[7]) begin
				cur_valid       = 1'b1;
				cur.code_point  = {13'd0, in_byte};
				cur.byte_count  = 3'd1;
				cur.escaped     = 1'b0;
			end else if (is_cont || is_bad_lead || stream_end) begin
				cur_valid = 1'b1;
			end else begin
				hold_first = 1'b1;
			end
		end
	end

	// held bytes first, then the current result
	always_comb begin
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			if (flush && 2'(i) < hc_q)
				batch.entries[i] = esc_result(held_q[i]);
			else
				batch.entries[i] = cur;
		end
		batch.entries[RES_MAX-1] = cur;
		batch.count = (flush ? {1'b0, hc_q} : 3'd0) + {2'd0, cur_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= 2'd0;
			sl_q <= SEQ_NONE;
		end else if (take) begin
			if (hold_first) begin
				hc_q <= 2'd1;
				sl_q <= lead_len;
			end else if (hold_next) begin
				hc_q <= hc_q + 2'd1;
			end else begin
				hc_q <= 2'd0;
				sl_q <= SEQ_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && hold_first)
			held_q[0] <= in_byte;
		for (int i = 1; i < HOLD_DEPTH; i++) begin
			if (take && hold_next && hc_q == 2'(i))
				held_q[i] <= in_byte;
		end
	end

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != 2'd0 |-> ({1'b0, hc_q} < sl_q && sl_q >= SEQ_LEN2 && sl_q <= SEQ_LEN4))
		else $error("held count not below sequence length");

	a_idle_len: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q == 2'd0 |-> sl_q == SEQ_NONE)
		else $error("sequence length set with nothing held");

	a_batch_count: assert property (@(posedge clk) disable iff (!arst_n)
		batch.count <= 3'(RES_MAX))
		else $error("result batch larger than four");

endmodule

`default_nettype wire

/* sv/ude_result_buf.sv */
// ude_result_buf: register of one request's results, shifted out one per unstalled cycle
// depends on ude_pkg
`default_nettype none

module ude_result_buf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire ude_pkg::batch_t batch,
	output logic                 can_load,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [20:0]          code_point,
	output logic [2:0]           byte_count,
	output logic                 escaped,
	output logic                 run_last
);
	import ude_pkg::*;

	result_t list_q [RES_MAX];
	cnt_t    cnt_q;
	logic    take_out;

	assign out_valid  = (cnt_q != 3'd0);
	assign take_out   = out_valid && !out_stall;
	assign can_load   = (cnt_q == 3'd0) || (cnt_q == 3'd1 && take_out);
	assign code_point = list_q[0].code_point;
	assign byte_count = list_q[0].byte_count;
	assign escaped    = list_q[0].escaped;
	assign run_last   = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (take_out) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < RES_MAX; i++)
				list_q[i] <= batch.entries[i];
		end else if (take_out) begin
			for (int i = 0; i < RES_MAX - 1; i++)
				list_q[i] <= list_q[i+1];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(RES_MAX))
		else $error("result count out of range");

	a_load_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && take_out)))
		else $error("batch loaded over pending results");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cnt_q) && $stable(list_q[0]))
		else $error("pending result changed under stall");

endmodule

`default_nettype wire

/* sv/utf8_decoder_byte_escape_top.sv */
// utf8_decoder_byte_escape_top: top level of the utf-8 byte decoder with byte escapes
// depends on ude_pkg, ude_decode, ude_result_buf
//
// One raw byte is taken per request. ASCII bytes and completed 2-, 3- and 4-byte
// sequences each give one code point; undecodable bytes give 0xDC80 | low 7 bits
// with escaped set. run_last marks the final result of each input byte, and a byte
// that only extends a pending sequence gives none. A result appears the cycle after
// its byte is taken. The block takes one byte per cycle while out_stall is low and
// each byte gives at most one result; a byte that breaks a pending sequence or ends
// the stream inside one gives up to four results, sent one per unstalled cycle
// through the single result port; the input stalls until the last one is being taken.
`default_nettype none

module utf8_decoder_byte_escape_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        stream_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [20:0]      code_point,
	output logic [2:0]       byte_count,
	output logic             escaped,
	output logic             run_last
);
	import ude_pkg::*;

	batch_t batch;
	logic   can_load;
	logic   take;

	assign in_stall = !can_load;
	assign take     = in_valid && can_load;

	ude_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.batch      (batch)
	);

	ude_result_buf u_result_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.batch      (batch),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.byte_count (byte_count),
		.escaped    (escaped),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire

/* test/tb_utf8_decoder_byte_escape_top.sv */
// tb_utf8_decoder_byte_escape_top: self-checking testbench of the utf-8 byte decoder
// depends on ude_pkg and utf8_decoder_byte_escape_top; directed table, then random
// byte streams checked against an in-bench decoder, with random gaps and stalls
`timescale 1ns / 1ps

module tb_utf8_decoder_byte_escape_top;
	import ude_pkg::*;

	localparam int N_RANDOM = 145;
	localparam int IDLE_LIMIT = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int N_DIRECTED = 25;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  byte_count;
		logic        escaped;
		logic        run_last;
	} cp_res_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        eos;
		logic        typed;
		logic [20:0] cp;
		logic        esc;
	} byte_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        stream_end;
	logic        out_valid;
	logic        out_stall;
	logic [20:0] code_point;
	logic [2:0]  byte_count;
	logic        escaped;
	logic        run_last;

	utf8_decoder_byte_escape_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.byte_count (byte_count),
		.escaped    (escaped),
		.run_last   (run_last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// directed rows; cp/esc typed in only where typed is set
	byte_row_t dir_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
		'{8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0},
		'{8'h80, 1'b0, 1'b1, 21'h00DC80, 1'b1},
		'{8'hBF, 1'b0, 1'b1, 21'h00DCBF, 1'b1},
		'{8'hF8, 1'b0, 1'b1, 21'h00DCF8, 1'b1},
		'{8'hFF, 1'b0, 1'b1, 21'h00DCFF, 1'b1},
		'{8'hC5, 1'b1, 1'b1, 21'h00DCC5, 1'b1},
		'{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hA9, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h82, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hAC, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hF7, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hC3, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
		'{8'hE1, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h80, 1'b1, 1'b0, 21'h0, 1'b0}
	};

	byte_row_t   byte_stream [$];
	cp_res_t     cp_expect [$];
	cp_res_t     step_res [$];

	logic [7:0]  pend_bytes [HOLD_DEPTH];
	int          pend_cnt;
	logic [2:0]  pend_len;

	int          n_fail;
	int          n_checked;
	int          n_escapes;
	int          idle_cycles;
	int          chk_idx;
	bit          send_fast;
	bit          recv_fast;

	function automatic int draw_wait(input bit fast);
		return fast ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic void push_escape(input logic [7:0] b);
		cp_res_t r;
		r.code_point = ESC_BASE | {14'd0, b[6:0]};
		r.byte_count = 3'd1;
		r.escaped    = 1'b1;
		r.run_last   = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void flush_pending();
		for (int i = 0; i < pend_cnt; i++)
			push_escape(pend_bytes[i]);
		pend_cnt = 0;
		pend_len = SEQ_NONE;
	endfunction

	// advances the decoder state by one byte, results land in step_res
	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		logic [31:0] v;
		cp_res_t     r;
		bit          taken;
		taken = 1'b0;
		step_res.delete();
		if (pend_cnt != 0) begin
			if (b[7:6] == 2'b10) begin
				taken = 1'b1;
				if (pend_cnt + 1 >= int'(pend_len)) begin
					v = (pend_len == SEQ_LEN2) ? {27'd0, pend_bytes[0][4:0]}
						: {28'd0, pend_bytes[0][3:0]};
					for (int i = 1; i < pend_cnt; i++)
						v = (v << 6) | {26'd0, pend_bytes[i][5:0]};
					v = (v << 6) | {26'd0, b[5:0]};
					r.code_point = v[20:0];
					r.byte_count = pend_len;
					r.escaped    = 1'b0;
					r.run_last   = 1'b0;
					step_res.push_back(r);
					pend_cnt = 0;
					pend_len = SEQ_NONE;
				end else if (eos) begin
					flush_pending();
					push_escape(b);
				end else begin
					pend_bytes[pend_cnt] = b;
					pend_cnt++;
				end
			end else begin
				flush_pending();
			end
		end
		if (!taken) begin
			if (b[7] == 1'b0) begin
				r.code_point = {13'd0, b};
				r.byte_count = 3'd1;
				r.escaped    = 1'b0;
				r.run_last   = 1'b0;
				step_res.push_back(r);
			end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
				push_escape(b);
			end else if (eos) begin
				push_escape(b);
			end else begin
				pend_bytes[0] = b;
				pend_cnt = 1;
				if (b[7:5] == 3'b110)
					pend_len = SEQ_LEN2;
				else if (b[7:4] == 4'b1110)
					pend_len = SEQ_LEN3;
				else
					pend_len = SEQ_LEN4;
			end
		end
		if (step_res.size() > 0)
			step_res[step_res.size()-1].run_last = 1'b1;
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic eos);
		byte_row_t row;
		row = '0;
		row.b = b;
		row.eos = eos;
		byte_stream.push_back(row);
	endfunction

	// checker and predictor, both on accepted handshakes
	always @(posedge clk) begin
		cp_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (escaped)
					n_escapes++;
				if (cp_expect.size() == 0) begin
					$error("unexpected result: code_point %h", code_point);
					n_fail++;
				end else begin
					want = cp_expect.pop_front();
					if (code_point !== want.code_point) begin
						$error("code_point: expected %h, got %h", want.code_point, code_point);
						n_fail++;
					end
					if (byte_count !== want.byte_count) begin
						$error("byte_count: expected %0d, got %0d", want.byte_count, byte_count);
						n_fail++;
					end
					if (escaped !== want.escaped) begin
						$error("escaped: expected %b, got %b", want.escaped, escaped);
						n_fail++;
					end
					if (run_last !== want.run_last) begin
						$error("run_last: expected %b, got %b", want.run_last, run_last);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_byte, stream_end);
				if (chk_idx < byte_stream.size() && byte_stream[chk_idx].typed) begin
					want.code_point = byte_stream[chk_idx].cp;
					want.byte_count = 3'd1;
					want.escaped    = byte_stream[chk_idx].esc;
					want.run_last   = 1'b1;
					cp_expect.push_back(want);
				end else begin
					foreach (step_res[i])
						cp_expect.push_back(step_res[i]);
				end
				chk_idx++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("utf8_decoder_byte_escape_top regression: fail");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_fast = !recv_fast;
			n = draw_wait(recv_fast);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int        kind;
		int        len;
		int        nc;
		int        gap;
		int        idx;
		int        n_sent;
		logic      brk_eos;
		logic      end_here;
		logic [7:0] lead;
		logic [7:0] nb;
		byte_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		stream_end = 1'b0;
		out_stall = 1'b0;
		n_fail = 0;
		n_checked = 0;
		n_escapes = 0;
		idle_cycles = 0;
		chk_idx = 0;
		pend_cnt = 0;
		pend_len = SEQ_NONE;
		send_fast = 1'b0;
		recv_fast = 1'b0;
		n_sent = 0;

		for (int i = 0; i < N_DIRECTED; i++)
			byte_stream.push_back(dir_rows[i]);

		// random streams: mostly well-formed sequences, some broken ones and noise
		while (byte_stream.size() < N_DIRECTED + N_RANDOM) begin
			kind = $urandom_range(0, 9);
			end_here = ($urandom_range(0, 7) == 0);
			if (kind <= 2) begin
				add_byte({1'b0, 7'($urandom)}, end_here);
			end else if (kind == 9) begin
				add_byte(8'($urandom), end_here);
			end else begin
				len = $urandom_range(2, 4);
				case (len)
					2: lead = {3'b110, 5'($urandom)};
					3: lead = {4'b1110, 4'($urandom)};
					default: lead = {5'b11110, 3'($urandom)};
				endcase
				nc = (kind <= 6) ? len - 1 : $urandom_range(0, len - 2);
				brk_eos = (kind > 6) && ($urandom_range(0, 1) == 1);
				add_byte(lead, brk_eos && nc == 0);
				for (int j = 1; j <= nc; j++)
					add_byte({2'b10, 6'($urandom)},
						(j == nc) && (brk_eos || (kind <= 6 && end_here)));
				if (kind > 6 && !brk_eos) begin
					do nb = 8'($urandom); while (nb[7:6] == 2'b10);
					add_byte(nb, end_here);
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < N_DIRECTED + N_RANDOM && idx < byte_stream.size()) begin
			// hold off until the decoder has drained, after the directed part and now and then
			if (idx == N_DIRECTED || $urandom_range(0, 39) == 0) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (cp_expect.size() != 0);
			end
			if ($urandom_range(0, 29) == 0)
				send_fast = !send_fast;
			gap = draw_wait(send_fast);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			row = byte_stream[idx];
			in_valid <= 1'b1;
			in_byte <= row.b;
			stream_end <= row.eos;
			do @(posedge clk); while (in_stall);
			n_sent++;
			idx++;
		end
		in_valid <= 1'b0;

		while (cp_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d request bytes (%0d from the directed table), random gaps and stalls",
			n_sent, N_DIRECTED);
		$display("checked %0d code points, %0d of them byte escapes", n_checked, n_escapes);
		if (n_fail == 0 && cp_expect.size() == 0)
			$display("utf8_decoder_byte_escape_top regression: pass");
		else
			$display("utf8_decoder_byte_escape_top regression: fail");
		$finish;
	end

endmodule
